[hw/rtl/iotcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iotcs_pkg
// shared constants and controller/datapath interface types for the scheduler
// ----------------------------------------------------------------------------
package iotcs_pkg;

    localparam int unsigned TASK_IDS_DEF  = 256;
    localparam int unsigned TIME_BITS_DEF = 32;
    localparam int unsigned ID_W          = 8;
    localparam int unsigned ID_RANGE      = 256;
    localparam int unsigned CFG_W         = 16;
    localparam int unsigned GAP_W         = CFG_W + 1;
    localparam int unsigned OUT_W         = 32;

    typedef struct packed {
        logic load;
        logic diff;
        logic gap;
        logic adv;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

[hw/rtl/in_order_task_cooldown_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_task_cooldown_scheduler
// in-order task issue on a saturating slot counter with per-task cooldown
// ----------------------------------------------------------------------------
// Each task beat yields one result beat. The sequencer runs its steps one
// after another, from acceptance up to a loaded result: memory read of the
// task's last slot, the difference to the counter, the cooldown gap, the
// saturating advance and the final write-back and increment. The next task
// is taken only once the result has loaded, so one task is in progress at
// a time. The result sits in an output register, so a new task is taken
// while a result still waits; the finish step holds only while that register
// is full and not being read. first_of_list clears the counter and all seen
// marks at once. The user is to write cooldown_slots through i_cfg_we /
// i_cfg_wdata only while idle; the block itself does not enforce this.
module in_order_task_cooldown_scheduler #(
    parameter int unsigned TASK_IDS  = iotcs_pkg::TASK_IDS_DEF,
    parameter int unsigned TIME_BITS = iotcs_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [iotcs_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // task_id
    input  logic                          s_axis_tuser,  // first_of_list
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [2*iotcs_pkg::OUT_W-1:0] m_axis_tdata,  // issue_slot, total_time
    output logic                          m_axis_tuser   // time_overflow
);
    import iotcs_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [OUT_W-1:0] w_slot;
    logic [OUT_W-1:0] w_total;

    iotcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    iotcs_dp #(
        .TASK_IDS  (TASK_IDS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_task_id    (s_axis_tdata),
        .i_first      (s_axis_tuser),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_issue_slot (w_slot),
        .o_total_time (w_total),
        .o_overflow   (m_axis_tuser)
    );

    assign m_axis_tdata = {w_total, w_slot};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("task accepted while one is in progress");

    a_total_follows_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        (m_axis_tdata[2*OUT_W-1:OUT_W] == (m_axis_tdata[OUT_W-1:0] + OUT_W'(1))))
        else $error("total_time is not issue_slot plus one");

    a_sat_reuses_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[2*OUT_W-1:OUT_W] == m_axis_tdata[OUT_W-1:0]))
        else $error("saturated step did not hold the slot");

    a_fin_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.fin) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten");
`endif

endmodule

[hw/rtl/iotcs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iotcs_ctrl
// sequencer: accept, difference, gap, advance, finish
// ----------------------------------------------------------------------------
module iotcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  iotcs_pkg::t_sts i_sts,
    output iotcs_pkg::t_cmd o_cmd
);
    import iotcs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_GAP  = 3'd2;
    localparam logic [2:0] S_ADV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_GAP;
            end
            S_GAP: begin
                o_cmd.gap = 1'b1;
                n_state   = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/iotcs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iotcs_dp
// slot counter, per-task history memory, seen marks and result register
// ----------------------------------------------------------------------------
module iotcs_dp #(
    parameter int unsigned TASK_IDS  = iotcs_pkg::TASK_IDS_DEF,
    parameter int unsigned TIME_BITS = iotcs_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [iotcs_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic [iotcs_pkg::ID_W-1:0]  i_task_id,
    input  logic                        i_first,
    input  iotcs_pkg::t_cmd             i_cmd,
    output iotcs_pkg::t_sts             o_sts,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [iotcs_pkg::OUT_W-1:0] o_issue_slot,
    output logic [iotcs_pkg::OUT_W-1:0] o_total_time,
    output logic                        o_overflow
);
    import iotcs_pkg::*;

    localparam int unsigned LIVE  = (TASK_IDS < ID_RANGE) ? TASK_IDS : ID_RANGE;
    localparam int unsigned IDX_W = $clog2(LIVE);
    localparam int unsigned CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int unsigned SUM_W = ((TIME_BITS > GAP_W) ? TIME_BITS : GAP_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [IDX_W-1:0]     w_id_map [ID_RANGE];
    logic [TIME_BITS-1:0] r_mem    [LIVE];

    logic [CFG_W-1:0]     r_cool;
    logic [LIVE-1:0]      r_seen;
    logic [TIME_BITS-1:0] r_cnt;
    logic                 r_ovf;
    logic                 r_valid;
    logic [IDX_W-1:0]     r_id;
    logic [TIME_BITS-1:0] r_rdata;
    logic [TIME_BITS-1:0] r_since;
    logic                 r_seen_hit;
    logic                 r_hit;
    logic [GAP_W-1:0]     r_gap;
    logic [OUT_W-1:0]     r_out_slot;
    logic [OUT_W-1:0]     r_out_total;
    logic                 r_out_ovf;

    logic [SUM_W-1:0]           w_sum;
    logic                       w_sum_sat;
    logic                       w_inc_sat;
    logic [TIME_BITS-1:0]       w_inc;
    logic [TIME_BITS+OUT_W-1:0] w_slot_ext;
    logic [TIME_BITS+OUT_W-1:0] w_total_ext;

    // label reduced to the table range
    for (genvar g = 0; g < ID_RANGE; g++) begin : g_id_map
        localparam int unsigned MAPPED = g % TASK_IDS;
        assign w_id_map[g] = IDX_W'(MAPPED);
    end

    assign w_sum       = SUM_W'(r_cnt) + SUM_W'(r_gap);
    assign w_sum_sat   = (w_sum > SUM_W'(TIME_MAX));
    assign w_inc_sat   = (r_cnt == TIME_MAX);
    assign w_inc       = w_inc_sat ? TIME_MAX : (r_cnt + TIME_BITS'(1));
    assign w_slot_ext  = {{OUT_W{1'b0}}, r_cnt};
    assign w_total_ext = {{OUT_W{1'b0}}, w_inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cool  <= '0;
            r_seen  <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cool <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_ovf <= 1'b0;
                if (i_first) begin
                    r_cnt  <= '0;
                    r_seen <= '0;
                end
            end
            if (i_cmd.adv && r_hit) begin
                if (w_sum_sat) begin
                    r_cnt <= TIME_MAX;
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= w_sum[TIME_BITS-1:0];
                end
            end
            if (i_cmd.fin) begin
                r_seen[r_id] <= 1'b1;
                r_cnt        <= w_inc;
                r_valid      <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id <= w_id_map[i_task_id];
        end
        if (i_cmd.diff) begin
            r_since    <= r_cnt - r_rdata;
            r_seen_hit <= r_seen[r_id];
        end
        if (i_cmd.gap) begin
            r_hit <= r_seen_hit && (CMP_W'(r_since) <= CMP_W'(r_cool));
            r_gap <= GAP_W'(r_cool) - GAP_W'(r_since) + GAP_W'(1);
        end
        if (i_cmd.fin) begin
            r_out_slot  <= w_slot_ext[OUT_W-1:0];
            r_out_total <= w_total_ext[OUT_W-1:0];
            r_out_ovf   <= r_ovf | w_inc_sat;
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rdata <= r_mem[w_id_map[i_task_id]];
        end
        if (i_cmd.fin) begin
            r_mem[r_id] <= r_cnt;
        end
    end

    assign o_sts.out_busy = r_valid && !i_ready;
    assign o_valid        = r_valid;
    assign o_issue_slot   = r_out_slot;
    assign o_total_time   = r_out_total;
    assign o_overflow     = r_out_ovf;

endmodule
